>>> src/ecp_pkg.sv
package ecp_pkg;

  localparam int unsigned BUFFER_DEPTH_DEFAULT = 64;

  localparam logic [7:0] OP_STATUS   = 8'h10;
  localparam logic [7:0] OP_WRITE    = 8'h20;
  localparam logic [7:0] OP_READ     = 8'h30;
  localparam logic [7:0] REPLY_READY = 8'hd0;
  localparam logic [7:0] REPLY_DONE  = 8'hd1;

  // kind of result item loaded into the output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_PLAIN,
    EMIT_READY,
    EMIT_DONE,
    EMIT_READ,
    EMIT_WRITE
  } emit_e;

  typedef struct packed {
    emit_e emit;
    logic  busy;
    logic  load_hi;
    logic  load_lo;
    logic  load_size;
    logic  clear_fill;
    logic  store_byte;
    logic  clear_idx;
    logic  rd_buf;
    logic  drain_step;
  } cmd_t;

  typedef struct packed {
    logic fill_done;
    logic size_zero;
    logic drain_last;
    logic out_free;
  } sts_t;

endpackage

>>> src/eeprom_serial_command_parser_unit.sv
// Serial command parser for a byte-wide memory programmer. Each received byte
// (rx_byte_i) answers with one result item: idle 0x10 replies ready (0xd0),
// 0x20 opens a write (address high, address low, size clamped to BUFFER_DEPTH,
// then data bytes) and 0x30 opens a read (address high, address low, size)
// that ends in one read request. The final data byte of a write instead drains
// the data buffer as one write item per byte, the last one carrying the
// completion reply 0xd1; the buffer has a single registered read port, so
// each byte is first read (SEQ_DRAIN_RD) and then loaded as a write item
// (SEQ_DRAIN_WR), and no byte is taken until the drain is through. A write
// of size zero absorbs BUFFER_DEPTH bytes and gives only the 0xd1 reply. A
// byte is taken only while the output register is empty or is being emptied
// in the same cycle, so a result waiting under out_stall_i holds off the
// input. The buffer has no reset and needs no clearing pass.
module eeprom_serial_command_parser_unit #(
  parameter int unsigned BUFFER_DEPTH = ecp_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        reply_valid_o,
  output logic [7:0]  reply_byte_o,
  output logic        write_valid_o,
  output logic [15:0] write_base_o,
  output logic [5:0]  write_offset_o,
  output logic [7:0]  write_data_o,
  output logic        read_request_o,
  output logic [15:0] read_address_o,
  output logic [6:0]  read_count_o,
  output logic        busy_res_o,
  output logic        last_o
);
  import ecp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ecp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ecp_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .reply_valid_o  (reply_valid_o),
    .reply_byte_o   (reply_byte_o),
    .write_valid_o  (write_valid_o),
    .write_base_o   (write_base_o),
    .write_offset_o (write_offset_o),
    .write_data_o   (write_data_o),
    .read_request_o (read_request_o),
    .read_address_o (read_address_o),
    .read_count_o   (read_count_o),
    .busy_res_o     (busy_res_o),
    .last_o         (last_o)
  );

endmodule

>>> src/ecp_ctrl.sv
module ecp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    rx_byte_i,
  input  ecp_pkg::sts_t sts_i,
  output ecp_pkg::cmd_t cmd_o
);
  import ecp_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WRITE,
    MODE_READ
  } mode_e;

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_LOW,
    PH_SIZE,
    PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    SEQ_ACCEPT,
    SEQ_DRAIN_RD,
    SEQ_DRAIN_WR
  } seq_e;

  mode_e  mode_q, mode_d;
  phase_e phase_q, phase_d;
  seq_e   seq_q, seq_d;
  logic   accept;

  assign in_stall_o = !((seq_q == SEQ_ACCEPT) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    seq_d   = seq_q;
    cmd_o   = '0;
    cmd_o.emit = EMIT_NONE;
    unique case (seq_q)
      SEQ_ACCEPT: begin
        if (accept) begin
          unique case (mode_q)
            MODE_WRITE: begin
              cmd_o.emit = EMIT_PLAIN;
              cmd_o.busy = 1'b1;
              unique case (phase_q)
                PH_HIGH: begin
                  cmd_o.load_hi = 1'b1;
                  phase_d = PH_LOW;
                end
                PH_LOW: begin
                  cmd_o.load_lo = 1'b1;
                  phase_d = PH_SIZE;
                end
                PH_SIZE: begin
                  cmd_o.load_size = 1'b1;
                  phase_d = PH_DATA;
                end
                PH_DATA: begin
                  cmd_o.store_byte = 1'b1;
                  if (sts_i.fill_done) begin
                    mode_d = MODE_IDLE;
                    if (sts_i.size_zero) begin
                      cmd_o.emit = EMIT_DONE;
                      cmd_o.busy = 1'b0;
                    end else begin
                      // results come out of the buffer one by one
                      cmd_o.emit      = EMIT_NONE;
                      cmd_o.clear_idx = 1'b1;
                      seq_d = SEQ_DRAIN_RD;
                    end
                  end
                end
              endcase
            end
            MODE_READ: begin
              unique case (phase_q)
                PH_HIGH: begin
                  cmd_o.emit    = EMIT_PLAIN;
                  cmd_o.busy    = 1'b1;
                  cmd_o.load_hi = 1'b1;
                  phase_d = PH_LOW;
                end
                PH_LOW: begin
                  cmd_o.emit    = EMIT_PLAIN;
                  cmd_o.busy    = 1'b1;
                  cmd_o.load_lo = 1'b1;
                  phase_d = PH_SIZE;
                end
                default: begin
                  cmd_o.emit      = EMIT_READ;
                  cmd_o.load_size = 1'b1;
                  mode_d = MODE_IDLE;
                end
              endcase
            end
            default: begin
              // idle, also the unused mode code
              mode_d     = MODE_IDLE;
              cmd_o.emit = EMIT_PLAIN;
              if (rx_byte_i == OP_STATUS) begin
                cmd_o.emit = EMIT_READY;
              end else if (rx_byte_i == OP_WRITE) begin
                mode_d  = MODE_WRITE;
                phase_d = PH_HIGH;
                cmd_o.clear_fill = 1'b1;
                cmd_o.busy = 1'b1;
              end else if (rx_byte_i == OP_READ) begin
                mode_d  = MODE_READ;
                phase_d = PH_HIGH;
                cmd_o.busy = 1'b1;
              end
            end
          endcase
        end
      end
      SEQ_DRAIN_RD: begin
        cmd_o.rd_buf = 1'b1;
        seq_d = SEQ_DRAIN_WR;
      end
      SEQ_DRAIN_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = EMIT_WRITE;
          cmd_o.drain_step = 1'b1;
          seq_d = sts_i.drain_last ? SEQ_ACCEPT : SEQ_DRAIN_RD;
        end
      end
      default: begin
        seq_d = SEQ_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= PH_HIGH;
      seq_q   <= SEQ_ACCEPT;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      seq_q   <= seq_d;
    end
  end

endmodule

>>> src/ecp_dpath.sv
module ecp_dpath #(
  parameter int unsigned BUFFER_DEPTH = ecp_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    rx_byte_i,
  input  ecp_pkg::cmd_t cmd_i,
  output ecp_pkg::sts_t sts_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic          reply_valid_o,
  output logic [7:0]    reply_byte_o,
  output logic          write_valid_o,
  output logic [15:0]   write_base_o,
  output logic [5:0]    write_offset_o,
  output logic [7:0]    write_data_o,
  output logic          read_request_o,
  output logic [15:0]   read_address_o,
  output logic [6:0]    read_count_o,
  output logic          busy_res_o,
  output logic          last_o
);
  import ecp_pkg::*;

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  logic [15:0]   address_q;
  logic [CW-1:0] size_q;
  logic [CW-1:0] fill_q;
  logic [CW-1:0] idx_q;
  logic [7:0]    buf_mem [BUFFER_DEPTH];
  logic [7:0]    rdata_q;

  logic [CW-1:0] size_clamp;
  logic [CW-1:0] fill_inc;
  logic [CW-1:0] idx_inc;
  logic          out_free;

  logic          out_valid_q, out_valid_d;
  logic          reply_valid_q;
  logic [7:0]    reply_byte_q;
  logic          write_valid_q;
  logic [15:0]   write_base_q;
  logic [5:0]    write_offset_q;
  logic [7:0]    write_data_q;
  logic          read_request_q;
  logic [15:0]   read_address_q;
  logic [6:0]    read_count_q;
  logic          busy_res_q;
  logic          last_q;

  assign size_clamp = ({1'b0, rx_byte_i} < 9'(BUFFER_DEPTH)) ? CW'(rx_byte_i)
                                                             : CW'(BUFFER_DEPTH);
  assign fill_inc = fill_q + 1'b1;
  assign idx_inc  = idx_q + 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.fill_done  = (fill_inc == size_q) || (fill_inc == CW'(BUFFER_DEPTH));
  assign sts_o.size_zero  = (size_q == '0);
  assign sts_o.drain_last = (idx_inc == size_q);
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q <= '0;
      size_q    <= '0;
      fill_q    <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.load_hi) begin
        address_q <= {rx_byte_i, 8'h00};
      end else if (cmd_i.load_lo) begin
        address_q <= address_q | {8'h00, rx_byte_i};
      end
      if (cmd_i.load_size) begin
        size_q <= size_clamp;
      end
      if (cmd_i.clear_fill) begin
        fill_q <= '0;
      end else if (cmd_i.store_byte) begin
        fill_q <= fill_inc;
      end
      if (cmd_i.clear_idx) begin
        idx_q <= '0;
      end else if (cmd_i.drain_step) begin
        idx_q <= idx_inc;
      end
    end
  end

  // fill position never reaches the depth while a data byte is stored
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) begin
      buf_mem[fill_q[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_buf) begin
      rdata_q <= buf_mem[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit != EMIT_NONE) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EMIT_NONE) begin
      reply_valid_q  <= 1'b0;
      reply_byte_q   <= '0;
      write_valid_q  <= 1'b0;
      write_base_q   <= '0;
      write_offset_q <= '0;
      write_data_q   <= '0;
      read_request_q <= 1'b0;
      read_address_q <= '0;
      read_count_q   <= '0;
      busy_res_q     <= 1'b0;
      last_q         <= 1'b1;
      unique case (cmd_i.emit)
        EMIT_PLAIN: begin
          busy_res_q <= cmd_i.busy;
        end
        EMIT_READY: begin
          reply_valid_q <= 1'b1;
          reply_byte_q  <= REPLY_READY;
        end
        EMIT_DONE: begin
          reply_valid_q <= 1'b1;
          reply_byte_q  <= REPLY_DONE;
        end
        EMIT_READ: begin
          read_request_q <= 1'b1;
          read_address_q <= address_q;
          read_count_q   <= 7'(size_clamp);
        end
        EMIT_WRITE: begin
          write_valid_q  <= 1'b1;
          write_base_q   <= address_q;
          write_offset_q <= 6'(idx_q);
          write_data_q   <= rdata_q;
          reply_valid_q  <= sts_o.drain_last;
          reply_byte_q   <= sts_o.drain_last ? REPLY_DONE : 8'h00;
          last_q         <= sts_o.drain_last;
        end
        EMIT_NONE: begin
          last_q <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign reply_valid_o  = reply_valid_q;
  assign reply_byte_o   = reply_byte_q;
  assign write_valid_o  = write_valid_q;
  assign write_base_o   = write_base_q;
  assign write_offset_o = write_offset_q;
  assign write_data_o   = write_data_q;
  assign read_request_o = read_request_q;
  assign read_address_o = read_address_q;
  assign read_count_o   = read_count_q;
  assign busy_res_o     = busy_res_q;
  assign last_o         = last_q;

endmodule

>>> verif/tb_top.sv
module tb_top;
  import ecp_pkg::*;

  localparam int unsigned DEPTH = BUFFER_DEPTH_DEFAULT;

  typedef enum logic [1:0] {MD_IDLE, MD_WRITE, MD_READ} parse_mode_e;
  typedef enum logic [1:0] {ST_ADDR_HI, ST_ADDR_LO, ST_SIZE, ST_DATA} parse_step_e;

  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        write_valid;
    logic [15:0] write_base;
    logic [5:0]  write_offset;
    logic [7:0]  write_data;
    logic        read_request;
    logic [15:0] read_address;
    logic [6:0]  read_count;
    logic        busy;
    logic        last;
  } parse_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        reply_valid_o;
  logic [7:0]  reply_byte_o;
  logic        write_valid_o;
  logic [15:0] write_base_o;
  logic [5:0]  write_offset_o;
  logic [7:0]  write_data_o;
  logic        read_request_o;
  logic [15:0] read_address_o;
  logic [6:0]  read_count_o;
  logic        busy_res_o;
  logic        last_o;

  eeprom_serial_command_parser_unit #(
    .BUFFER_DEPTH(DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .reply_valid_o (reply_valid_o),
    .reply_byte_o  (reply_byte_o),
    .write_valid_o (write_valid_o),
    .write_base_o  (write_base_o),
    .write_offset_o(write_offset_o),
    .write_data_o  (write_data_o),
    .read_request_o(read_request_o),
    .read_address_o(read_address_o),
    .read_count_o  (read_count_o),
    .busy_res_o    (busy_res_o),
    .last_o        (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // parser state as seen by the checker
  parse_mode_e   cur_mode = MD_IDLE;
  parse_step_e   cur_step = ST_ADDR_HI;
  logic [15:0]   cur_addr = 16'h0000;
  logic [6:0]    cur_size = 7'd0;
  logic [6:0]    fill_pos = 7'd0;
  logic [7:0]    data_buf [DEPTH];

  parse_result_t expected_results [$];
  logic [7:0]    rx_pending [$];
  int            queued_total = 0;
  int            err_cnt = 0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int            holdoff_left = 0;
  logic          holdoff_arm = 1'b0;
  logic          in_taken = 1'b0;
  int            idle_tab [4] = '{0, 88, 0, 20};
  int            stall_tab [4] = '{0, 0, 88, 20};

  function automatic void parse_rx_byte(input logic [7:0] b);
    parse_result_t r;
    int k;
    r = '0;
    r.last = 1'b1;
    case (cur_mode)
      MD_WRITE: begin
        case (cur_step)
          ST_ADDR_HI: begin
            cur_addr = {b, 8'h00};
            cur_step = ST_ADDR_LO;
          end
          ST_ADDR_LO: begin
            cur_addr[7:0] = b;
            cur_step = ST_SIZE;
          end
          ST_SIZE: begin
            cur_size = (b < DEPTH) ? 7'(b) : 7'(DEPTH);
            cur_step = ST_DATA;
          end
          default: begin
            if (fill_pos < DEPTH) data_buf[fill_pos] = b;
            fill_pos++;
            if (fill_pos == cur_size || fill_pos >= DEPTH) begin
              cur_mode = MD_IDLE;
              if (cur_size == 0) begin
                r.reply_valid = 1'b1;
                r.reply_byte = REPLY_DONE;
              end else begin
                // drain the buffer, completion reply rides on the final write
                for (k = 0; k < cur_size; k++) begin
                  r = '0;
                  r.write_valid = 1'b1;
                  r.write_base = cur_addr;
                  r.write_offset = k[5:0];
                  r.write_data = data_buf[k];
                  if (k + 1 == cur_size) begin
                    r.reply_valid = 1'b1;
                    r.reply_byte = REPLY_DONE;
                    r.last = 1'b1;
                  end
                  expected_results.push_back(r);
                end
                return;
              end
            end
          end
        endcase
      end
      MD_READ: begin
        case (cur_step)
          ST_ADDR_HI: begin
            cur_addr = {b, 8'h00};
            cur_step = ST_ADDR_LO;
          end
          ST_ADDR_LO: begin
            cur_addr[7:0] = b;
            cur_step = ST_SIZE;
          end
          default: begin
            cur_size = (b < DEPTH) ? 7'(b) : 7'(DEPTH);
            cur_mode = MD_IDLE;
            r.read_request = 1'b1;
            r.read_address = cur_addr;
            r.read_count = cur_size;
          end
        endcase
      end
      default: begin
        cur_mode = MD_IDLE;
        if (b == OP_STATUS) begin
          r.reply_valid = 1'b1;
          r.reply_byte = REPLY_READY;
        end else if (b == OP_WRITE) begin
          cur_mode = MD_WRITE;
          cur_step = ST_ADDR_HI;
          fill_pos = 7'd0;
        end else if (b == OP_READ) begin
          cur_mode = MD_READ;
          cur_step = ST_ADDR_HI;
        end
      end
    endcase
    r.busy = (cur_mode != MD_IDLE);
    expected_results.push_back(r);
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    queued_total++;
  endfunction

  function automatic void add_write(input logic [15:0] addr, input logic [7:0] size_byte);
    int n;
    n = (size_byte == 0 || size_byte > DEPTH) ? DEPTH : size_byte;
    queue_byte(OP_WRITE);
    queue_byte(addr[15:8]);
    queue_byte(addr[7:0]);
    queue_byte(size_byte);
    repeat (n) queue_byte(8'($urandom_range(255)));
  endfunction

  function automatic void add_read(input logic [15:0] addr, input logic [7:0] size_byte);
    queue_byte(OP_READ);
    queue_byte(addr[15:8]);
    queue_byte(addr[7:0]);
    queue_byte(size_byte);
  endfunction

  function automatic void add_random(input int budget);
    int goal;
    int pick;
    goal = queued_total + budget;
    while (queued_total < goal) begin
      pick = $urandom_range(99);
      if (pick < 40) add_write(16'($urandom), 8'($urandom_range(1, 6)));
      else if (pick < 45) add_write(16'($urandom), 8'($urandom_range(7, 24)));
      else if (pick < 72) add_read(16'($urandom), 8'($urandom_range(255)));
      else if (pick < 82) queue_byte(OP_STATUS);
      else if (pick < 94) rx_pending.push_back(8'($urandom_range(255)));
      else if (pick < 97) begin
        // header cut short, following bytes get parsed as its fields
        queue_byte(OP_WRITE);
        queue_byte(8'($urandom_range(255)));
      end else begin
        queue_byte(OP_READ);
        queue_byte(8'($urandom_range(255)));
      end
    end
  endfunction

  // sender: hold a byte until its transfer, then maybe offer the next
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        rx_byte_i <= rx_pending.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (holdoff_left != 0) holdoff_left <= holdoff_left - 1;
    else if (holdoff_arm) holdoff_left <= 300;
  end

  always @(negedge clk_i) begin
    out_stall_i <= (holdoff_left != 0) || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    parse_result_t got;
    parse_result_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {reply_valid_o, reply_byte_o, write_valid_o, write_base_o, write_offset_o,
               write_data_o, read_request_o, read_address_o, read_count_o, busy_res_o,
               last_o};
        if (expected_results.size() == 0) begin
          if (err_cnt < 10) $display("unexpected result transfer: %p", got);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (err_cnt < 10) $display("result mismatch\n  expected %p\n  actual   %p", want, got);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        parse_rx_byte(rx_byte_i);
      end
    end
  end

  initial begin
    int ph;
    rx_pending = {OP_STATUS, 8'h00, 8'hff,
                  OP_READ, 8'hff, 8'hff, 8'hff,
                  OP_READ, 8'h00, 8'h00, 8'h00,
                  OP_READ, 8'h00, 8'h01, 8'h40,
                  OP_WRITE, 8'h12, 8'h34, 8'h01, 8'ha5,
                  OP_WRITE, 8'hff, 8'hff, 8'h02, 8'h00, 8'hff};
    add_write(16'h8001, 8'h00);
    add_write(16'($urandom), 8'h40);
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      add_random(70);
      if (ph == 0) begin
        repeat (6) @(negedge clk_i);
        rst_ni <= 1'b1;
        // long receiver hold-off while bytes keep coming
        holdoff_arm = 1'b1;
        while (holdoff_left == 0) @(posedge clk_i);
        holdoff_arm = 1'b0;
      end
      while (rx_pending.size() != 0 || in_valid_i) @(posedge clk_i);
    end
    stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #50000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> eeprom_serial_command_parser_unit.f
src/ecp_pkg.sv
src/ecp_ctrl.sv
src/ecp_dpath.sv
src/eeprom_serial_command_parser_unit.sv
verif/tb_top.sv
